// ----- rtl/atapio_pkg.sv -----
`default_nettype none
package atapio_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int NUM_SECTORS  = 32;
    localparam int BYTE_AW      = $clog2(SECTOR_BYTES);
    localparam int SECT_W       = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam int IMG_DEPTH    = NUM_SECTORS * SECTOR_BYTES;
    localparam int IMG_AW       = $clog2(IMG_DEPTH);

    localparam logic [7:0] ST_READY = 8'h40;
    localparam logic [7:0] ST_DRQ   = 8'h08;

    localparam logic [7:0] CMD_READ0  = 8'h20;
    localparam logic [7:0] CMD_READ1  = 8'h21;
    localparam logic [7:0] CMD_WRITE0 = 8'h30;
    localparam logic [7:0] CMD_WRITE1 = 8'h31;
    localparam logic [7:0] CMD_IDENT  = 8'hEC;

    localparam logic [3:0] OFF_DATA     = 4'd0;
    localparam logic [3:0] OFF_TF_FIRST = 4'd1;
    localparam logic [3:0] OFF_TF_LAST  = 4'd6;
    localparam logic [3:0] OFF_CMD      = 4'd7;
    localparam logic [3:0] OFF_HIGH     = 4'd8;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_REG     = 4'd2;
    localparam logic [3:0] OP_CMD     = 4'd3;
    localparam logic [3:0] OP_RD_ADDR = 4'd4;
    localparam logic [3:0] OP_RD_LO   = 4'd5;
    localparam logic [3:0] OP_RD_HI   = 4'd6;
    localparam logic [3:0] OP_WR_LO   = 4'd7;
    localparam logic [3:0] OP_WR_HI   = 4'd8;
    localparam logic [3:0] OP_ADV     = 4'd9;
    localparam logic [3:0] OP_XFER    = 4'd10;
    localparam logic [3:0] OP_SECEND  = 4'd11;

    localparam logic [1:0] XK_FETCH = 2'd0;
    localparam logic [1:0] XK_CLEAR = 2'd1;
    localparam logic [1:0] XK_IDENT = 2'd2;
    localparam logic [1:0] XK_STORE = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic req_write;
        logic off_data;
        logic off_cmd;
        logic word_ok;
        logic write_mode;
        logic cmd_starts;
        logic sector_end;
        logic xfer_done;
        logic xfer_store;
        logic more_sectors;
    } dp_stat_t;

    function automatic logic [7:0] boot_byte(input logic [8:0] a);
        logic [7:0] b;
        case (a)
            9'd0:   b = 8'h4C;
            9'd1:   b = 8'h49;
            9'd2:   b = 8'h42;
            9'd3:   b = 8'h43;
            9'd4:   b = 8'h50;
            9'd5:   b = 8'h55;
            9'd6:   b = 8'h20;
            9'd7:   b = 8'h58;
            9'd8:   b = 8'h54;
            9'd9:   b = 8'h2D;
            9'd10:  b = 8'h49;
            9'd11:  b = 8'h44;
            9'd12:  b = 8'h45;
            9'd13:  b = 8'h20;
            9'd14:  b = 8'h53;
            9'd15:  b = 8'h45;
            9'd16:  b = 8'h43;
            9'd17:  b = 8'h54;
            9'd18:  b = 8'h4F;
            9'd19:  b = 8'h52;
            9'd20:  b = 8'h20;
            9'd21:  b = 8'h30;
            9'd22:  b = 8'h20;
            9'd23:  b = 8'h2D;
            9'd24:  b = 8'h20;
            9'd25:  b = 8'h50;
            9'd26:  b = 8'h49;
            9'd27:  b = 8'h4F;
            9'd28:  b = 8'h20;
            9'd29:  b = 8'h52;
            9'd30:  b = 8'h45;
            9'd31:  b = 8'h41;
            9'd32:  b = 8'h44;
            9'd33:  b = 8'h20;
            9'd34:  b = 8'h4F;
            9'd35:  b = 8'h4B;
            9'd510: b = 8'h55;
            9'd511: b = 8'hAA;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ident_byte(input logic [8:0] a);
        logic [7:0] b;
        case (a)
            9'd0:   b = 8'h40;
            9'd54:  b = 8'h49;
            9'd55:  b = 8'h4C;
            9'd56:  b = 8'h43;
            9'd57:  b = 8'h42;
            9'd58:  b = 8'h55;
            9'd59:  b = 8'h50;
            9'd60:  b = 8'h58;
            9'd61:  b = 8'h20;
            9'd62:  b = 8'h49;
            9'd63:  b = 8'h54;
            9'd64:  b = 8'h45;
            9'd65:  b = 8'h44;
            9'd66:  b = 8'h44;
            9'd67:  b = 8'h20;
            9'd68:  b = 8'h53;
            9'd69:  b = 8'h49;
            9'd70:  b = 8'h20;
            9'd71:  b = 8'h4B;
            9'd120: b = 8'(NUM_SECTORS);
            9'd121: b = 8'(NUM_SECTORS >> 8);
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/atapio_ram.sv -----
`default_nettype none
module atapio_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [W-1:0]             rdata_reg
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/atapio_ctrl.sv -----
`default_nettype none
module atapio_ctrl
    import atapio_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t st,
    output dp_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD_LO  = 4'd2;
    localparam logic [3:0] S_RD_HI  = 4'd3;
    localparam logic [3:0] S_WR_HI  = 4'd4;
    localparam logic [3:0] S_ADV    = 4'd5;
    localparam logic [3:0] S_XFER   = 4'd6;
    localparam logic [3:0] S_SECEND = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.off_data) begin
                    if (!st.req_write) begin
                        if (st.word_ok) begin
                            cmd.op     = OP_RD_ADDR;
                            state_next = S_RD_LO;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else if (st.write_mode && st.word_ok) begin
                        cmd.op     = OP_WR_LO;
                        state_next = S_WR_HI;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (st.off_cmd && st.req_write) begin
                    cmd.op     = OP_CMD;
                    state_next = st.cmd_starts ? S_XFER : S_DONE;
                end else begin
                    cmd.op     = OP_REG;
                    state_next = S_DONE;
                end
            end
            S_RD_LO: begin
                cmd.op     = OP_RD_LO;
                state_next = S_RD_HI;
            end
            S_RD_HI: begin
                cmd.op     = OP_RD_HI;
                state_next = S_ADV;
            end
            S_WR_HI: begin
                cmd.op     = OP_WR_HI;
                state_next = S_ADV;
            end
            S_ADV: begin
                cmd.op = OP_ADV;
                if (st.sector_end) begin
                    state_next = st.write_mode ? S_XFER : S_SECEND;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_XFER: begin
                cmd.op = OP_XFER;
                if (st.xfer_done) begin
                    state_next = st.xfer_store ? S_SECEND : S_DONE;
                end
            end
            S_SECEND: begin
                cmd.op     = OP_SECEND;
                state_next = st.more_sectors ? S_XFER : S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/atapio_dp.sv -----
`default_nettype none
module atapio_dp
    import atapio_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        st,
    input  wire logic       s_req_type,
    input  wire logic [3:0] s_port_offset,
    input  wire logic [7:0] s_write_data,
    output logic      [7:0] m_read_data
);

    logic                    req_write_reg;
    logic [3:0]              req_off_reg;
    logic [7:0]              req_data_reg;
    logic [7:0]              result_reg;
    logic [7:0]              out_data_reg;

    logic [7:0]              tf_reg [6];
    logic [7:0]              status_reg;
    logic [7:0]              latch_reg;
    logic [9:0]              bi_reg;
    logic [16:0]             words_reg;
    logic [31:0]             lba_reg;
    logic                    wm_reg;
    logic [9:0]              cnt_reg;
    logic [1:0]              xk_reg;
    logic [NUM_SECTORS-1:0]  valid_reg;

    logic [BYTE_AW-1:0] buf_raddr, buf_waddr;
    logic [7:0]         buf_wdata, buf_rdata;
    logic               buf_we;
    logic [IMG_AW-1:0]  img_raddr, img_waddr;
    logic [7:0]         img_rdata;
    logic               img_we;

    logic               word_ok, sector_end, lba_in, xfer_done, more, cmd_starts;
    logic               tf_off;
    logic [10:0]        bi_plus2;
    logic [SECT_W-1:0]  sect;
    logic [8:0]         count9;
    logic [31:0]        tf_lba;
    logic [BYTE_AW-1:0] cnt_prev;
    logic [2:0]         tf_idx;
    logic [7:0]         fill_data;

    assign word_ok    = (words_reg != 17'd0) && (bi_reg < 10'(SECTOR_BYTES - 1));
    assign bi_plus2   = {1'b0, bi_reg} + 11'd2;
    assign sector_end = bi_plus2 >= 11'(SECTOR_BYTES);
    assign lba_in     = lba_reg < 32'(NUM_SECTORS);
    assign sect       = lba_reg[SECT_W-1:0];
    assign count9     = (tf_reg[1] == 8'd0) ? 9'd256 : {1'b0, tf_reg[1]};
    assign tf_lba     = {4'd0, tf_reg[5][3:0], tf_reg[4], tf_reg[3], tf_reg[2]};
    assign cnt_prev   = cnt_reg[BYTE_AW-1:0] - BYTE_AW'(1);
    assign xfer_done  = cnt_reg == 10'(SECTOR_BYTES);
    assign more       = words_reg > 17'd256;
    assign tf_off     = (req_off_reg >= OFF_TF_FIRST) && (req_off_reg <= OFF_TF_LAST);
    assign tf_idx     = 3'(req_off_reg - OFF_TF_FIRST);
    assign cmd_starts = (req_data_reg == CMD_READ0) || (req_data_reg == CMD_READ1) ||
                        (req_data_reg == CMD_WRITE0) || (req_data_reg == CMD_WRITE1) ||
                        (req_data_reg == CMD_IDENT);

    always_comb begin
        case (xk_reg)
            XK_FETCH: begin
                if (!lba_in) begin
                    fill_data = 8'h00;
                end else if (valid_reg[sect]) begin
                    fill_data = img_rdata;
                end else if (lba_reg == 32'd0) begin
                    fill_data = boot_byte(cnt_prev);
                end else begin
                    fill_data = 8'h00;
                end
            end
            XK_IDENT: fill_data = ident_byte(cnt_prev);
            default:  fill_data = 8'h00;
        endcase
    end

    always_comb begin
        buf_raddr = bi_reg[BYTE_AW-1:0];
        buf_we    = 1'b0;
        buf_waddr = bi_reg[BYTE_AW-1:0];
        buf_wdata = req_data_reg;
        case (cmd.op)
            OP_RD_LO: buf_raddr = bi_reg[BYTE_AW-1:0] + BYTE_AW'(1);
            OP_WR_LO: buf_we = 1'b1;
            OP_WR_HI: begin
                buf_we    = 1'b1;
                buf_waddr = bi_reg[BYTE_AW-1:0] + BYTE_AW'(1);
                buf_wdata = latch_reg;
            end
            OP_XFER: begin
                if (xk_reg == XK_STORE) begin
                    buf_raddr = cnt_reg[BYTE_AW-1:0];
                end else begin
                    buf_we    = cnt_reg != 10'd0;
                    buf_waddr = cnt_prev;
                    buf_wdata = fill_data;
                end
            end
            default: ;
        endcase
    end

    assign img_raddr = IMG_AW'({sect, cnt_reg[BYTE_AW-1:0]});
    assign img_waddr = IMG_AW'({sect, cnt_prev});
    assign img_we    = (cmd.op == OP_XFER) && (xk_reg == XK_STORE) &&
                       (cnt_reg != 10'd0) && lba_in;

    atapio_ram #(.W(8), .DEPTH(SECTOR_BYTES)) u_buf (
        .aclk      (aclk),
        .we        (buf_we),
        .waddr     (buf_waddr),
        .wdata     (buf_wdata),
        .raddr     (buf_raddr),
        .rdata_reg (buf_rdata)
    );

    atapio_ram #(.W(8), .DEPTH(IMG_DEPTH)) u_img (
        .aclk      (aclk),
        .we        (img_we),
        .waddr     (img_waddr),
        .wdata     (buf_rdata),
        .raddr     (img_raddr),
        .rdata_reg (img_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            req_write_reg <= s_req_type;
            req_off_reg   <= s_port_offset;
            req_data_reg  <= s_write_data;
            result_reg    <= 8'h00;
        end else if (cmd.op == OP_REG && !req_write_reg) begin
            if (tf_off) begin
                result_reg <= tf_reg[tf_idx];
            end else if (req_off_reg == OFF_CMD) begin
                result_reg <= status_reg;
            end else if (req_off_reg == OFF_HIGH) begin
                result_reg <= latch_reg;
            end
        end else if (cmd.op == OP_RD_LO) begin
            result_reg <= buf_rdata;
        end
        if (cmd.out_load) begin
            out_data_reg <= result_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                tf_reg[i] <= 8'h00;
            end
            status_reg <= ST_READY;
            latch_reg  <= 8'h00;
            bi_reg     <= 10'd0;
            words_reg  <= 17'd0;
            lba_reg    <= 32'd0;
            wm_reg     <= 1'b0;
            cnt_reg    <= 10'd0;
            xk_reg     <= XK_FETCH;
            valid_reg  <= '0;
        end else begin
            case (cmd.op)
                OP_REG: begin
                    if (req_write_reg) begin
                        if (tf_off) begin
                            tf_reg[tf_idx] <= req_data_reg;
                        end else if (req_off_reg == OFF_HIGH) begin
                            latch_reg <= req_data_reg;
                        end
                    end
                end
                OP_CMD: begin
                    status_reg <= ST_READY | ST_DRQ;
                    bi_reg     <= 10'd0;
                    cnt_reg    <= 10'd0;
                    if (req_data_reg == CMD_READ0 || req_data_reg == CMD_READ1) begin
                        lba_reg   <= tf_lba;
                        words_reg <= {count9, 8'd0};
                        wm_reg    <= 1'b0;
                        xk_reg    <= XK_FETCH;
                    end else if (req_data_reg == CMD_WRITE0 || req_data_reg == CMD_WRITE1) begin
                        lba_reg   <= tf_lba;
                        words_reg <= {count9, 8'd0};
                        wm_reg    <= 1'b1;
                        xk_reg    <= XK_CLEAR;
                    end else if (req_data_reg == CMD_IDENT) begin
                        words_reg <= 17'd256;
                        wm_reg    <= 1'b0;
                        xk_reg    <= XK_IDENT;
                    end else begin
                        status_reg <= ST_READY;
                        bi_reg     <= bi_reg;
                    end
                end
                OP_RD_HI: latch_reg <= buf_rdata;
                OP_ADV: begin
                    bi_reg <= bi_plus2[9:0];
                    if (sector_end && wm_reg) begin
                        xk_reg  <= XK_STORE;
                        cnt_reg <= 10'd0;
                    end
                end
                OP_XFER: begin
                    if (xfer_done) begin
                        cnt_reg <= 10'd0;
                        if (xk_reg == XK_STORE && lba_in) begin
                            valid_reg[sect] <= 1'b1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 10'd1;
                    end
                end
                OP_SECEND: begin
                    words_reg <= (words_reg >= 17'd256) ? (words_reg - 17'd256) : 17'd0;
                    cnt_reg   <= 10'd0;
                    if (more) begin
                        lba_reg <= lba_reg + 32'd1;
                        bi_reg  <= 10'd0;
                        xk_reg  <= wm_reg ? XK_CLEAR : XK_FETCH;
                    end else begin
                        status_reg <= ST_READY;
                        wm_reg     <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign st.req_write    = req_write_reg;
    assign st.off_data     = req_off_reg == OFF_DATA;
    assign st.off_cmd      = req_off_reg == OFF_CMD;
    assign st.word_ok      = word_ok;
    assign st.write_mode   = wm_reg;
    assign st.cmd_starts   = cmd_starts;
    assign st.sector_end   = sector_end;
    assign st.xfer_done    = xfer_done;
    assign st.xfer_store   = xk_reg == XK_STORE;
    assign st.more_sectors = more;

    assign m_read_data = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/ata_pio_task_file_8bit_bridge_top.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_req_type, s_port_offset, s_write_data
// m_       out        m_valid/m_ready    m_read_data
//
// Steps: register access decode; data read decode, RD_LO, RD_HI, ADV; write decode,
// WR_HI, ADV; then done. A starting command adds a fetch, clear or identify pass. Read
// sector end adds SECEND and a fetch (none on the last); write sector end adds store,
// then clear (none on the last). Reset is synchronous; unwritten sectors read as reset
// image. s_ready drops while an item is in work; one result may wait in the output.
`default_nettype none
module ata_pio_task_file_8bit_bridge_top
    import atapio_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire logic [3:0] s_port_offset,
    input  wire logic [7:0] s_write_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_read_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_st;

    atapio_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (dp_st),
        .cmd     (dp_cmd)
    );

    atapio_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .st            (dp_st),
        .s_req_type    (s_req_type),
        .s_port_offset (s_port_offset),
        .s_write_data  (s_write_data),
        .m_read_data   (m_read_data)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while item in work");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without item");

    a_xfer_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_st.xfer_done |-> !s_ready)
        else $error("buffer pass while idle");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import atapio_pkg::*;

    localparam int IMG_BYTES = NUM_SECTORS * SECTOR_BYTES;

    typedef struct packed {
        logic       is_write;
        logic [3:0] offset;
        logic [7:0] data;
    } bus_access_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = 1'b0;
    logic [3:0] s_port_offset = 4'd0;
    logic [7:0] s_write_data = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;

    ata_pio_task_file_8bit_bridge_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_port_offset(s_port_offset), .s_write_data(s_write_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data)
    );

    always #1 aclk = ~aclk;

    // drive state mirror
    logic [7:0]  tf [6];
    logic [7:0]  stat_q;
    logic [7:0]  hi_latch;
    int unsigned byte_idx;
    int unsigned words_rem;
    logic [31:0] lba_q;
    logic        wr_mode;
    logic [7:0]  sec_buf [SECTOR_BYTES];
    logic [7:0]  disk [IMG_BYTES];

    bus_access_t access_q[$];
    logic [7:0]  read_data_q[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_cmds = 0;
    bit          calm = 1'b0;
    bit          stim_done = 1'b0;

    function automatic logic [7:0] boot_img(int a);
        logic [7:0] tag [36];
        tag = '{8'h4C, 8'h49, 8'h42, 8'h43, 8'h50, 8'h55, 8'h20, 8'h58, 8'h54,
                8'h2D, 8'h49, 8'h44, 8'h45, 8'h20, 8'h53, 8'h45, 8'h43, 8'h54,
                8'h4F, 8'h52, 8'h20, 8'h30, 8'h20, 8'h2D, 8'h20, 8'h50, 8'h49,
                8'h4F, 8'h20, 8'h52, 8'h45, 8'h41, 8'h44, 8'h20, 8'h4F, 8'h4B};
        if (a < 36) return tag[a];
        if (a == 510) return 8'h55;
        if (a == 511) return 8'hAA;
        return 8'h00;
    endfunction

    task automatic disk_reset();
        for (int i = 0; i < 6; i++) tf[i] = 8'd0;
        stat_q = ST_READY;
        hi_latch = 8'd0;
        byte_idx = 0;
        words_rem = 0;
        lba_q = 32'd0;
        wr_mode = 1'b0;
        for (int i = 0; i < SECTOR_BYTES; i++) sec_buf[i] = 8'd0;
        for (int i = 0; i < IMG_BYTES; i++) disk[i] = (i < SECTOR_BYTES) ? boot_img(i) : 8'd0;
    endtask

    function automatic void load_sector(logic [31:0] l);
        for (int i = 0; i < SECTOR_BYTES; i++)
            sec_buf[i] = (l < NUM_SECTORS) ? disk[l * SECTOR_BYTES + i] : 8'd0;
        byte_idx = 0;
    endfunction

    function automatic void clear_buf();
        for (int i = 0; i < SECTOR_BYTES; i++) sec_buf[i] = 8'd0;
        byte_idx = 0;
    endfunction

    function automatic void advance_word();
        byte_idx += 2;
        if (byte_idx >= SECTOR_BYTES) begin
            if (wr_mode && lba_q < NUM_SECTORS)
                for (int i = 0; i < SECTOR_BYTES; i++)
                    disk[lba_q * SECTOR_BYTES + i] = sec_buf[i];
            words_rem = (words_rem >= 256) ? words_rem - 256 : 0;
            if (words_rem > 0) begin
                lba_q = lba_q + 32'd1;
                if (wr_mode) clear_buf();
                else load_sector(lba_q);
            end else begin
                stat_q = ST_READY;
                wr_mode = 1'b0;
            end
        end
    endfunction

    function automatic void start_command(logic [7:0] c);
        int unsigned cnt;
        logic [7:0] model [18];
        model = '{8'h49, 8'h4C, 8'h43, 8'h42, 8'h55, 8'h50, 8'h58, 8'h20, 8'h49,
                  8'h54, 8'h45, 8'h44, 8'h44, 8'h20, 8'h53, 8'h49, 8'h20, 8'h4B};
        cnt = (tf[1] == 8'd0) ? 256 : tf[1];
        case (c)
            CMD_READ0, CMD_READ1: begin
                lba_q = {4'd0, tf[5][3:0], tf[4], tf[3], tf[2]};
                load_sector(lba_q);
                words_rem = cnt * 256;
                wr_mode = 1'b0;
                stat_q = ST_READY | ST_DRQ;
            end
            CMD_WRITE0, CMD_WRITE1: begin
                lba_q = {4'd0, tf[5][3:0], tf[4], tf[3], tf[2]};
                clear_buf();
                words_rem = cnt * 256;
                wr_mode = 1'b1;
                stat_q = ST_READY | ST_DRQ;
            end
            CMD_IDENT: begin
                clear_buf();
                sec_buf[0] = 8'h40;
                sec_buf[120] = 8'(NUM_SECTORS);
                sec_buf[121] = 8'(NUM_SECTORS >> 8);
                for (int i = 0; i < 18; i++) sec_buf[54 + i] = model[i];
                words_rem = 256;
                wr_mode = 1'b0;
                stat_q = ST_READY | ST_DRQ;
            end
            default: stat_q = ST_READY;
        endcase
    endfunction

    function automatic logic [7:0] bus_access(bus_access_t a);
        logic [7:0] r;
        bit ok;
        r = 8'd0;
        ok = words_rem > 0 && byte_idx + 1 < SECTOR_BYTES;
        if (!a.is_write) begin
            if (a.offset == OFF_DATA) begin
                if (ok) begin
                    r = sec_buf[byte_idx];
                    hi_latch = sec_buf[byte_idx + 1];
                    advance_word();
                end
            end else if (a.offset <= OFF_TF_LAST) r = tf[a.offset - 1];
            else if (a.offset == OFF_CMD) r = stat_q;
            else if (a.offset == OFF_HIGH) r = hi_latch;
        end else begin
            if (a.offset == OFF_DATA) begin
                if (wr_mode && ok) begin
                    sec_buf[byte_idx] = a.data;
                    sec_buf[byte_idx + 1] = hi_latch;
                    advance_word();
                end
            end else if (a.offset <= OFF_TF_LAST) tf[a.offset - 1] = a.data;
            else if (a.offset == OFF_CMD) start_command(a.data);
            else if (a.offset == OFF_HIGH) hi_latch = a.data;
        end
        return r;
    endfunction

    // driver
    int s_idle = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                read_data_q.push_back(bus_access({s_req_type, s_port_offset, s_write_data}));
            end
            if (!s_valid || s_ready) begin
                if (s_idle > 0) begin
                    s_idle--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    s_idle = $urandom_range(1, 14);
                    s_valid <= 1'b0;
                end else if (access_q.size() > 0) begin
                    bus_access_t a;
                    a = access_q.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= a.is_write;
                    s_port_offset <= a.offset;
                    s_write_data <= a.data;
                end else begin
                    s_valid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // ready pattern
    int m_idle = 0;
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (m_idle > 0) begin
            m_idle--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            m_idle = $urandom_range(1, 14);
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    // monitor; the driver logs an accepted item at the negedge when s_ready returns,
    // before the monitor can take its result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (read_data_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result read_data=%02h", $realtime, m_read_data);
            end else begin
                logic [7:0] e;
                e = read_data_q.pop_front();
                if (e !== m_read_data) begin
                    errors++;
                    $display("%0t: read_data expected %02h actual %02h",
                             $realtime, e, m_read_data);
                end
            end
        end
    end

    function automatic bus_access_t acc(logic w, logic [3:0] o, logic [7:0] d);
        bus_access_t a;
        a.is_write = w;
        a.offset = o;
        a.data = d;
        return a;
    endfunction

    task automatic add_lba(logic [27:0] l, logic [7:0] cnt);
        access_q.push_back(acc(1'b1, 4'd2, cnt));
        access_q.push_back(acc(1'b1, 4'd3, l[7:0]));
        access_q.push_back(acc(1'b1, 4'd4, l[15:8]));
        access_q.push_back(acc(1'b1, 4'd5, l[23:16]));
        access_q.push_back(acc(1'b1, 4'd6, {4'($urandom_range(0, 15)), l[27:24]}));
    endtask

    task automatic add_rand_access();
        access_q.push_back(acc(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                               8'($urandom_range(0, 255))));
    endtask

    initial begin
        logic [7:0] cmd_list [6];
        logic [27:0] l;
        int k;
        cmd_list = '{CMD_READ0, CMD_READ1, CMD_WRITE0, CMD_WRITE1, CMD_IDENT, 8'h91};
        disk_reset();

        // directed
        for (int o = 1; o < 16; o++) access_q.push_back(acc(1'b0, 4'(o), 8'd0));
        access_q.push_back(acc(1'b0, OFF_DATA, 8'd0));
        access_q.push_back(acc(1'b1, OFF_DATA, 8'hFF));
        access_q.push_back(acc(1'b1, 4'd15, 8'hFF));
        access_q.push_back(acc(1'b1, 4'd9, 8'hA5));
        access_q.push_back(acc(1'b1, 4'd1, 8'hFF));
        access_q.push_back(acc(1'b0, 4'd1, 8'h00));
        access_q.push_back(acc(1'b1, OFF_CMD, CMD_IDENT));
        access_q.push_back(acc(1'b0, OFF_DATA, 8'h00));
        access_q.push_back(acc(1'b0, OFF_HIGH, 8'h00));
        access_q.push_back(acc(1'b0, OFF_CMD, 8'h00));
        access_q.push_back(acc(1'b1, OFF_CMD, 8'h00));
        access_q.push_back(acc(1'b0, OFF_CMD, 8'h00));

        // random: mostly well-formed command sequences
        while (access_q.size() < 600) begin
            k = $urandom_range(0, 9);
            if (k < 2) begin
                add_rand_access();
                continue;
            end
            case ($urandom_range(0, 3))
                0: l = 28'd0;
                1: l = 28'($urandom_range(0, NUM_SECTORS - 1));
                2: l = 28'(NUM_SECTORS - 1);
                default: l = 28'({$urandom, $urandom} & 28'hFFF_FFFF);
            endcase
            add_lba(l, ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 2)));
            access_q.push_back(acc(1'b1, OFF_CMD, cmd_list[$urandom_range(0, 5)]));
            n_cmds++;
            k = $urandom_range(1, 40);
            for (int i = 0; i < k; i++) begin
                case ($urandom_range(0, 9))
                    0: add_rand_access();
                    1: access_q.push_back(acc(1'b0, OFF_CMD, 8'd0));
                    2, 3: access_q.push_back(acc(1'b0, OFF_HIGH, 8'd0));
                    4, 5: access_q.push_back(acc(1'b1, OFF_HIGH, 8'($urandom_range(0, 255))));
                    6, 7: access_q.push_back(acc(1'b1, OFF_DATA, 8'($urandom_range(0, 255))));
                    default: access_q.push_back(acc(1'b0, OFF_DATA, 8'd0));
                endcase
            end
        end
        // fill a whole sector, then read it back to see the stored words
        add_lba(28'd1, 8'd1);
        access_q.push_back(acc(1'b1, OFF_HIGH, 8'h5A));
        access_q.push_back(acc(1'b1, OFF_CMD, CMD_WRITE0));
        n_cmds++;
        for (int i = 0; i < 256; i++) access_q.push_back(acc(1'b1, OFF_DATA, 8'(i)));
        add_lba(28'd1, 8'd1);
        access_q.push_back(acc(1'b1, OFF_CMD, CMD_READ0));
        n_cmds++;
        for (int i = 0; i < 256; i++) access_q.push_back(acc(1'b0, OFF_DATA, 8'd0));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (access_q.size() < 600);
        calm = 1'b1;
        wait (stim_done && !s_valid);
        wait (read_data_q.size() == 0);
        repeat (2000) @(posedge aclk);
        $display("covered %0d results over %0d command sequences, all offsets and extremes",
                 n_results, n_cmds);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
